[hw/rtl/gwwb_pkg.sv]
// Shared types and constants for the gray-world white balance block.
package gwwb_pkg;

    localparam int PIXEL_COUNT_BITS = 22;
    localparam int GAIN_FRAC_BITS   = 16;
    localparam int PIX_W            = 8;
    localparam int GAIN_INT_BITS    = 8;

    localparam int SUM_W   = PIXEL_COUNT_BITS + PIX_W;
    localparam int TOTAL_W = SUM_W + 2;
    localparam int DEN_W   = SUM_W + 2;
    localparam int GAIN_W  = GAIN_INT_BITS + GAIN_FRAC_BITS;
    localparam int REM_W   = DEN_W + GAIN_INT_BITS;
    localparam int PROD_W  = PIX_W + GAIN_W;

    // Integer bits, fraction bits and one extra bit for rounding.
    localparam int DIV_STEPS  = GAIN_INT_BITS + GAIN_FRAC_BITS + 1;
    localparam int QUO_W      = DIV_STEPS;
    localparam int STEP_CNT_W = $clog2(DIV_STEPS);

    localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << GAIN_FRAC_BITS;
    localparam logic [GAIN_W-1:0] GAIN_MAX = GAIN_W'(255) << GAIN_FRAC_BITS;
    localparam logic [PIX_W-1:0]  PIX_MAX  = '1;

    localparam logic CMD_GATHER = 1'b0;
    localparam logic CMD_APPLY  = 1'b1;

    typedef enum logic [1:0] {
        CH_RED,
        CH_GREEN,
        CH_BLUE
    } chan_t;

    typedef struct packed {
        logic             cmd;
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic             frame_end;
    } pix_in_t;

    typedef struct packed {
        logic [PIX_W-1:0] out_red;
        logic [PIX_W-1:0] out_green;
        logic [PIX_W-1:0] out_blue;
        logic             out_frame_end;
    } pix_out_t;

    // Controller to datapath commands for the gain update.
    typedef struct packed {
        logic  sum_total;
        logic  load;
        logic  check;
        logic  step;
        logic  store;
        logic  clear;
        chan_t chan;
    } gwwb_cmd_t;

endpackage

[hw/rtl/gwwb_datapath.sv]
// Datapath: channel sums, shared serial gain divider, gains and apply stage.
module gwwb_datapath
    import gwwb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  gwwb_cmd_t cmd,
    input  logic      accept,
    input  pix_in_t   pixel,
    input  logic      balanced_stall,
    output logic      balanced_valid,
    output pix_out_t  balanced
);

    logic [SUM_W-1:0]   sum_red_reg, sum_green_reg, sum_blue_reg;
    logic [SUM_W-1:0]   sum_red_next, sum_green_next, sum_blue_next;
    logic [GAIN_W-1:0]  gain_red_reg, gain_green_reg, gain_blue_reg;
    logic [GAIN_W-1:0]  gain_red_next, gain_green_next, gain_blue_next;
    logic [TOTAL_W-1:0] total_reg;
    logic [DEN_W-1:0]   den_reg;
    logic [REM_W-1:0]   rem_reg;
    logic [QUO_W-1:0]   quo_reg;
    logic               zero_reg, sat_reg;
    logic               out_valid_reg, out_valid_next;
    pix_out_t           out_reg;

    logic [SUM_W-1:0]  part;
    logic [REM_W-1:0]  den_sh, den_255, rem_diff;
    logic              rem_ge;
    logic [QUO_W:0]    rounded;
    logic [GAIN_W-1:0] new_gain;
    logic              gather_beat, apply_beat;

    function automatic logic [PIX_W-1:0] apply_gain(input logic [PIX_W-1:0] p,
                                                    input logic [GAIN_W-1:0] g);
        logic [PROD_W-1:0] prod;
        logic [PROD_W-1:0] shifted;
        prod    = PROD_W'(p) * PROD_W'(g) + (PROD_W'(1) << (GAIN_FRAC_BITS - 1));
        shifted = prod >> GAIN_FRAC_BITS;
        return (shifted > PROD_W'(PIX_MAX)) ? PIX_MAX : shifted[PIX_W-1:0];
    endfunction

    assign gather_beat = accept && (pixel.cmd == CMD_GATHER);
    assign apply_beat  = accept && (pixel.cmd == CMD_APPLY);

    always_comb
    begin
        unique case (cmd.chan)
            CH_RED:   part = sum_red_reg;
            CH_GREEN: part = sum_green_reg;
            CH_BLUE:  part = sum_blue_reg;
            default:  part = sum_red_reg;
        endcase
    end

    // Divisor aligned to the top integer quotient bit.
    assign den_sh   = REM_W'(den_reg) << (GAIN_INT_BITS - 1);
    assign den_255  = (REM_W'(den_reg) << GAIN_INT_BITS) - REM_W'(den_reg);
    assign rem_ge   = rem_reg >= den_sh;
    assign rem_diff = rem_ge ? (rem_reg - den_sh) : rem_reg;

    always_comb
    begin
        rounded = (QUO_W + 1)'(quo_reg) + (QUO_W + 1)'(1);
        if (zero_reg)
            new_gain = GAIN_ONE;
        else if (sat_reg || (rounded[QUO_W:1] > QUO_W'(GAIN_MAX)))
            new_gain = GAIN_MAX;
        else
            new_gain = rounded[GAIN_W:1];
    end

    always_comb
    begin
        sum_red_next   = sum_red_reg;
        sum_green_next = sum_green_reg;
        sum_blue_next  = sum_blue_reg;
        if (cmd.clear)
        begin
            sum_red_next   = '0;
            sum_green_next = '0;
            sum_blue_next  = '0;
        end
        else if (gather_beat)
        begin
            sum_red_next   = sum_red_reg + SUM_W'(pixel.red);
            sum_green_next = sum_green_reg + SUM_W'(pixel.green);
            sum_blue_next  = sum_blue_reg + SUM_W'(pixel.blue);
        end

        gain_red_next   = gain_red_reg;
        gain_green_next = gain_green_reg;
        gain_blue_next  = gain_blue_reg;
        if (cmd.store)
        begin
            unique case (cmd.chan)
                CH_RED:   gain_red_next   = new_gain;
                CH_GREEN: gain_green_next = new_gain;
                CH_BLUE:  gain_blue_next  = new_gain;
                default:  gain_red_next   = gain_red_reg;
            endcase
        end

        if (apply_beat)
            out_valid_next = 1'b1;
        else if (!balanced_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_red_reg    <= '0;
            sum_green_reg  <= '0;
            sum_blue_reg   <= '0;
            gain_red_reg   <= GAIN_ONE;
            gain_green_reg <= GAIN_ONE;
            gain_blue_reg  <= GAIN_ONE;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            sum_red_reg    <= sum_red_next;
            sum_green_reg  <= sum_green_next;
            sum_blue_reg   <= sum_blue_next;
            gain_red_reg   <= gain_red_next;
            gain_green_reg <= gain_green_next;
            gain_blue_reg  <= gain_blue_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Divider and output payload, no reset needed.
    always_ff @(posedge clk)
    begin
        if (cmd.sum_total)
            total_reg <= TOTAL_W'(sum_red_reg) + TOTAL_W'(sum_green_reg)
                       + TOTAL_W'(sum_blue_reg);
        if (cmd.load)
        begin
            den_reg  <= DEN_W'(part) + (DEN_W'(part) << 1);
            zero_reg <= (part == '0);
        end
        if (cmd.check)
        begin
            sat_reg <= REM_W'(total_reg) >= den_255;
            rem_reg <= REM_W'(total_reg);
            quo_reg <= '0;
        end
        else if (cmd.step)
        begin
            rem_reg <= rem_diff << 1;
            quo_reg <= {quo_reg[QUO_W-2:0], rem_ge};
        end
        if (apply_beat)
        begin
            out_reg.out_red       <= apply_gain(pixel.red, gain_red_reg);
            out_reg.out_green     <= apply_gain(pixel.green, gain_green_reg);
            out_reg.out_blue      <= apply_gain(pixel.blue, gain_blue_reg);
            out_reg.out_frame_end <= pixel.frame_end;
        end
    end

    assign balanced_valid = out_valid_reg;
    assign balanced       = out_reg;

endmodule

[hw/rtl/gwwb_ctrl.sv]
// Controller: sequences the per-channel gain division after a gather frame end.
module gwwb_ctrl
    import gwwb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    output gwwb_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TOTAL,
        ST_LOAD,
        ST_CHECK,
        ST_DIV,
        ST_STORE
    } state_t;

    state_t                state_reg, state_next;
    chan_t                 chan_reg, chan_next;
    logic [STEP_CNT_W-1:0] cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;

    always_comb
    begin
        state_next = state_reg;
        chan_next  = chan_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
                if (start)
                    state_next = ST_TOTAL;
            ST_TOTAL:
            begin
                chan_next  = CH_RED;
                state_next = ST_LOAD;
            end
            ST_LOAD:
                state_next = ST_CHECK;
            ST_CHECK:
            begin
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cnt_next = cnt_reg + STEP_CNT_W'(1);
                if (cnt_reg == STEP_CNT_W'(DIV_STEPS - 1))
                    state_next = ST_STORE;
            end
            ST_STORE:
            begin
                if (chan_reg == CH_BLUE)
                    state_next = ST_IDLE;
                else
                begin
                    chan_next  = (chan_reg == CH_RED) ? CH_GREEN : CH_BLUE;
                    state_next = ST_LOAD;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
        busy_next = (state_next != ST_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            chan_reg  <= CH_RED;
            cnt_reg   <= '0;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            chan_reg  <= chan_next;
            cnt_reg   <= cnt_next;
            busy_reg  <= busy_next;
        end
    end

    always_comb
    begin
        cmd.sum_total = (state_reg == ST_TOTAL);
        cmd.load      = (state_reg == ST_LOAD);
        cmd.check     = (state_reg == ST_CHECK);
        cmd.step      = (state_reg == ST_DIV);
        cmd.store     = (state_reg == ST_STORE);
        cmd.clear     = (state_reg == ST_STORE) && (chan_reg == CH_BLUE);
        cmd.chan      = chan_reg;
    end

    assign busy = busy_reg;

endmodule

[hw/rtl/gray_world_white_balance_top.sv]
// Gray-world white balance: gathers RGB channel sums, derives gains, applies them.
// Apply beat: one result, the cycle after acceptance; one pixel per cycle sustained
//   while pixel_stall is low. Gather beat: no result, likewise one pixel per cycle.
// Gather beat with frame_end: pixel_stall is then high while the shared restoring
//   divider runs TOTAL, then LOAD, CHECK, 25 DIV steps and STORE for each channel.
// Reset: asynchronous, active low; sums clear to zero, all gains return to 1.0.
module gray_world_white_balance_top
    import gwwb_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     pixel_valid,
    output logic     pixel_stall,
    input  pix_in_t  pixel,
    output logic     balanced_valid,
    input  logic     balanced_stall,
    output pix_out_t balanced
);

    gwwb_cmd_t cmd;
    logic      busy;
    logic      accept;
    logic      start;

    // Hold input while the gain update runs or the output register is blocked.
    assign pixel_stall = busy || (balanced_valid && balanced_stall);
    assign accept      = pixel_valid && !pixel_stall;

    // The last gather beat of a frame kicks off the gain update.
    assign start = accept && (pixel.cmd == CMD_GATHER) && pixel.frame_end;

    gwwb_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd)
    );

    gwwb_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .accept         (accept),
        .pixel          (pixel),
        .balanced_stall (balanced_stall),
        .balanced_valid (balanced_valid),
        .balanced       (balanced)
    );

endmodule
